/* hw/rtl/amdc_pkg.sv */
package amdc_pkg;

  // result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_HEADER  = 4'd1;
  localparam logic [3:0] ST_SHORT       = 4'd2;
  localparam logic [3:0] ST_BAD_CHECK   = 4'd3;
  localparam logic [3:0] ST_FIRST_SHORT = 4'd4;
  localparam logic [3:0] ST_OVER_LIMIT  = 4'd5;
  localparam logic [3:0] ST_ORPHAN      = 4'd6;
  localparam logic [3:0] ST_WRONG_CMD   = 4'd7;
  localparam logic [3:0] ST_CRC         = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADER      = 2'd0;
  localparam logic [1:0] CFG_ACK_COMMAND = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  // report layout
  localparam logic [16:0] POS_FIRST_FLAG = 17'd3;
  localparam logic [16:0] POS_LEN_LO     = 17'd4;
  localparam logic [16:0] POS_LEN_HI     = 17'd5;
  localparam logic [16:0] PAYLOAD_START  = 17'd6;
  localparam logic [16:0] MSG_OVERHEAD   = 17'd7;
  localparam int unsigned FIRST_FLAG_BIT = 7;

  // message layout
  localparam logic [12:0] MSG_CMD_POS    = 13'd0;
  localparam logic [12:0] MSG_CODE_POS   = 13'd1;
  localparam logic [12:0] MSG_DLEN_LO    = 13'd3;
  localparam logic [12:0] MSG_DLEN_HI    = 13'd4;
  localparam logic [16:0] MSG_CRC_OFFSET = 17'd5;
  localparam logic [12:0] MSG_COUNT_MAX  = 13'h1FFF;

  localparam logic [12:0] LIMIT_CAP       = 13'd4096;
  localparam logic [12:0] MAX_PAYLOAD_RST = 13'd256;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef struct packed {
    logic [12:0] message_length;
    logic [7:0]  ack_code;
    logic [3:0]  status;
  } amdc_result_t;

  // one byte of reflected crc-16/modbus
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/ack_message_deframer_checker_core.sv */
// Byte-stream checker for acknowledgement messages carried in transfer reports.
// One report byte is taken per clock on in_tdata[7:0], with in_tlast on the final
// byte of each report; header, xor check byte, payload length and message crc are
// all updated in the same cycle, so a byte can enter every cycle. When a report
// end finishes a message or reveals an error, one status item is pushed into the
// two-entry output buffer, whose registered head drives out_*, and in_tready
// drops only while two results wait to be taken. Configuration
// writes on cfg_* are always ready and must only be made while the block is idle.
module ack_message_deframer_checker_core #(
  parameter int REPORT_BYTES = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // report_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] status, [11:4] ack_code, [24:12] message_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import amdc_pkg::*;

  localparam int POS_W = $clog2(REPORT_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(REPORT_BYTES);
  localparam logic [16:0] RB17 = 17'(REPORT_BYTES);

  logic [7:0]       header_r, ack_cmd_r;
  logic [12:0]      max_payload_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [3:0]       rerr_r, rerr_nxt;
  logic             active_r, active_nxt;
  logic [12:0]      mcount_r, mcount_nxt;
  logic [15:0]      dlen_r, dlen_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      crc_rx_r, crc_rx_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       code_r, code_nxt;

  logic             in_acc;
  logic             buf_full;
  logic             push;
  amdc_result_t     res, out_res;
  logic [7:0]       b;
  logic [16:0]      pos17, plen17, dlen17, mc17;
  logic [16:0]      pos_n17, plen_n17, mc_n17, total;
  logic [12:0]      limit;
  logic             complete;
  logic [3:0]       st;

  assign in_tready = !buf_full;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign b         = in_tdata;

  assign pos17    = {{(17-POS_W){1'b0}}, pos_r};
  assign plen17   = {1'b0, plen_r};
  assign dlen17   = {1'b0, dlen_r};
  assign mc17     = {4'b0, mcount_r};
  assign limit    = (max_payload_r > LIMIT_CAP) ? LIMIT_CAP : max_payload_r;

  always_comb begin
    pos_nxt    = pos_r;
    plen_nxt   = plen_r;
    first_nxt  = first_r;
    acc_nxt    = acc_r;
    rerr_nxt   = rerr_r;
    active_nxt = active_r;
    mcount_nxt = mcount_r;
    dlen_nxt   = dlen_r;
    crc_nxt    = crc_r;
    crc_rx_nxt = crc_rx_r;
    cmd_nxt    = cmd_r;
    code_nxt   = code_r;
    st         = ST_OK;
    push       = 1'b0;
    pos_n17    = '0;
    plen_n17   = '0;
    mc_n17     = '0;
    total      = '0;
    complete   = 1'b0;

    if (in_acc && pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
      if (rerr_r == ST_OK) begin
        if (pos_r == '0) begin
          if (b != header_r) rerr_nxt = ST_BAD_HEADER;
        end else begin
          if (pos17 <= POS_LEN_HI || pos17 <= plen17 + MSG_CRC_OFFSET) acc_nxt = acc_r ^ b;
          if (pos17 == POS_FIRST_FLAG) begin
            first_nxt = b[FIRST_FLAG_BIT];
            if (b[FIRST_FLAG_BIT]) begin
              // a first packet restarts the message
              active_nxt = 1'b0;
              mcount_nxt = '0;
              dlen_nxt   = '0;
              crc_nxt    = CRC_INIT;
              crc_rx_nxt = '0;
              cmd_nxt    = '0;
              code_nxt   = '0;
            end else if (!active_r) begin
              rerr_nxt = ST_ORPHAN;
            end
          end else if (pos17 == POS_LEN_LO) begin
            plen_nxt = {8'h00, b};
          end else if (pos17 == POS_LEN_HI) begin
            plen_nxt = plen_r | {b, 8'h00};
            if ({1'b0, plen_nxt} + PAYLOAD_START >= RB17) rerr_nxt = ST_SHORT;
          end else if (pos17 >= PAYLOAD_START && pos17 <= plen17 + MSG_CRC_OFFSET) begin
            // payload byte joins the message
            if (mc17 < dlen17 + MSG_CRC_OFFSET) begin
              crc_nxt = crc16_byte(crc_r, b);
              if (mcount_r == MSG_CMD_POS) cmd_nxt = b;
              else if (mcount_r == MSG_CODE_POS) code_nxt = b;
              else if (mcount_r == MSG_DLEN_LO) dlen_nxt = {dlen_r[15:8], b};
              else if (mcount_r == MSG_DLEN_HI) dlen_nxt = {b, dlen_r[7:0]};
            end else if (mc17 == dlen17 + MSG_CRC_OFFSET) begin
              crc_rx_nxt = {crc_rx_r[15:8], b};
            end else if (mc17 == dlen17 + MSG_CRC_OFFSET + 17'd1) begin
              crc_rx_nxt = {b, crc_rx_r[7:0]};
            end
            if (mcount_r != MSG_COUNT_MAX) mcount_nxt = mcount_r + 1'b1;
          end else if (pos17 == plen17 + PAYLOAD_START) begin
            if (b != acc_r) rerr_nxt = ST_BAD_CHECK;
          end
        end
      end
    end

    if (in_acc && in_tlast) begin
      pos_n17  = {{(17-POS_W){1'b0}}, pos_nxt};
      plen_n17 = {1'b0, plen_nxt};
      mc_n17   = {4'b0, mcount_nxt};
      total    = {1'b0, dlen_nxt} + MSG_OVERHEAD;
      complete = (pos_n17 >= MSG_OVERHEAD) && (pos_n17 >= plen_n17 + MSG_OVERHEAD);
      st = rerr_nxt;
      if (st == ST_OK && !complete) st = ST_SHORT;
      if (st == ST_OK && first_nxt) begin
        if (plen_n17 < MSG_OVERHEAD) st = ST_FIRST_SHORT;
        else if (dlen_nxt > {3'b0, limit}) st = ST_OVER_LIMIT;
      end
      push       = 1'b1;
      active_nxt = 1'b0;
      if (st == ST_OK) begin
        if (mc_n17 > total) begin
          st = ST_ORPHAN;
        end else if (mc_n17 < total) begin
          // message continues in later reports
          push       = 1'b0;
          active_nxt = 1'b1;
        end else if (cmd_nxt != ack_cmd_r) begin
          st = ST_WRONG_CMD;
        end else if (crc_nxt != crc_rx_nxt) begin
          st = ST_CRC;
        end
      end
      pos_nxt   = '0;
      plen_nxt  = '0;
      acc_nxt   = '0;
      rerr_nxt  = ST_OK;
      first_nxt = 1'b0;
    end

    res.status         = st;
    res.ack_code       = (st == ST_OK) ? code_nxt : 8'h00;
    res.message_length = (st == ST_OK) ? mcount_nxt : 13'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r      <= '0;
      ack_cmd_r     <= '0;
      max_payload_r <= MAX_PAYLOAD_RST;
      pos_r         <= '0;
      plen_r        <= '0;
      first_r       <= 1'b0;
      acc_r         <= '0;
      rerr_r        <= ST_OK;
      active_r      <= 1'b0;
      mcount_r      <= '0;
      dlen_r        <= '0;
      crc_r         <= CRC_INIT;
      crc_rx_r      <= '0;
      cmd_r         <= '0;
      code_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER:      header_r      <= cfg_data[7:0];
          CFG_ACK_COMMAND: ack_cmd_r     <= cfg_data[7:0];
          CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      plen_r   <= plen_nxt;
      first_r  <= first_nxt;
      acc_r    <= acc_nxt;
      rerr_r   <= rerr_nxt;
      active_r <= active_nxt;
      mcount_r <= mcount_nxt;
      dlen_r   <= dlen_nxt;
      crc_r    <= crc_nxt;
      crc_rx_r <= crc_rx_nxt;
      cmd_r    <= cmd_nxt;
      code_r   <= code_nxt;
    end
  end

  amdc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {7'b0, out_res};

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX) else $error("report position past buffer size");

  a_report_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (pos_r == '0 && rerr_r == ST_OK && !first_r))
    else $error("report state not cleared at report end");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.status != ST_OK) |-> (res.ack_code == 8'h00 && res.message_length == 13'h0000))
    else $error("error result carries message fields");

  a_result_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_acc && in_tlast)) else $error("result outside report end");

endmodule

/* hw/rtl/amdc_out_buf.sv */
module amdc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  amdc_pkg::amdc_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output amdc_pkg::amdc_result_t out_data
);
  import amdc_pkg::*;

  logic [1:0]   cnt_r, cnt_nxt;
  amdc_result_t head_r, head_nxt;
  amdc_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = head_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("result pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && pop) |=> (head_r == $past(skid_r)))
    else $error("skid item lost on drain");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("buffer count out of range");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import amdc_pkg::*;

  localparam int REPORT_BYTES = 63;
  localparam int MAX_CHUNK    = REPORT_BYTES - 7;  // largest payload that fits one report
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tlast = 1'b0; // report_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [3:0] status, [11:4] ack_code, [24:12] message_length
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  ack_message_deframer_checker_core #(
    .REPORT_BYTES(REPORT_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // configuration as the block should hold it
  logic [7:0]  reg_header;
  logic [7:0]  reg_command;
  logic [12:0] reg_max_payload;

  // deframer state mirror
  int          rpt_pos;
  logic [15:0] pkt_len;
  bit          pkt_first;
  logic [7:0]  xor_acc;
  logic [3:0]  rpt_err;
  bit          msg_open;
  logic [12:0] msg_count;
  logic [15:0] decl_len;
  logic [15:0] crc_run;
  logic [15:0] crc_rx;
  logic [7:0]  cmd_seen;
  logic [7:0]  code_seen;

  amdc_result_t pending_acks[$];

  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  bit steady = 1'b0;

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_message();
    msg_count = '0;
    decl_len  = '0;
    crc_run   = CRC_INIT;
    crc_rx    = '0;
    cmd_seen  = '0;
    code_seen = '0;
  endfunction

  function automatic void clear_report();
    rpt_pos   = 0;
    pkt_len   = '0;
    xor_acc   = '0;
    rpt_err   = ST_OK;
    pkt_first = 1'b0;
  endfunction

  function automatic void message_accumulate(input logic [7:0] b);
    if (msg_count < decl_len + 5) begin
      crc_run = modbus_crc_step(crc_run, b);
      case (msg_count)
        MSG_CMD_POS:  cmd_seen = b;
        MSG_CODE_POS: code_seen = b;
        MSG_DLEN_LO:  decl_len[7:0] = b;
        MSG_DLEN_HI:  decl_len[15:8] = b;
        default: ;
      endcase
    end else if (msg_count == decl_len + 5) begin
      crc_rx[7:0] = b;
    end else if (msg_count == decl_len + 6) begin
      crc_rx[15:8] = b;
    end
    if (msg_count != MSG_COUNT_MAX) msg_count++;
  endfunction

  // advance the mirror by one accepted item, queue the status it causes
  function automatic void predict_deframe(input logic [7:0] b, input bit last);
    int           p;
    int           limit;
    int           total;
    logic [3:0]   st;
    amdc_result_t r;
    p = rpt_pos;
    if (p < REPORT_BYTES) begin
      rpt_pos = p + 1;
      if (rpt_err == ST_OK) begin
        if (p == 0) begin
          if (b != reg_header) rpt_err = ST_BAD_HEADER;
        end else begin
          if (p <= 5 || p <= pkt_len + 5) xor_acc ^= b;
          if (p == 3) begin
            pkt_first = b[FIRST_FLAG_BIT];
            if (pkt_first) begin
              msg_open = 1'b0;
              clear_message();
            end else if (!msg_open) begin
              rpt_err = ST_ORPHAN;
            end
          end else if (p == 4) begin
            pkt_len = {8'h00, b};
          end else if (p == 5) begin
            pkt_len[15:8] = b;
            if (pkt_len + 6 >= REPORT_BYTES) rpt_err = ST_SHORT;
          end else if (p >= 6 && p <= pkt_len + 5) begin
            message_accumulate(b);
          end else if (p == pkt_len + 6) begin
            if (b != xor_acc) rpt_err = ST_BAD_CHECK;
          end
        end
      end
    end
    if (!last) return;

    st = rpt_err;
    if (st == ST_OK && !(rpt_pos >= 7 && rpt_pos >= pkt_len + 7)) st = ST_SHORT;
    if (st == ST_OK && pkt_first) begin
      limit = (reg_max_payload > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(reg_max_payload);
      if (pkt_len < 7) st = ST_FIRST_SHORT;
      else if (decl_len > limit) st = ST_OVER_LIMIT;
    end
    clear_report();
    if (st == ST_OK) begin
      total = decl_len + 7;
      msg_open = 1'b1;
      if (msg_count > total) st = ST_ORPHAN;
      else if (msg_count < total) return;
      else if (cmd_seen != reg_command) st = ST_WRONG_CMD;
      else if (crc_run != crc_rx) st = ST_CRC;
    end
    msg_open = 1'b0;
    r.status         = st;
    r.ack_code       = (st == ST_OK) ? code_seen : '0;
    r.message_length = (st == ST_OK) ? msg_count : '0;
    pending_acks.push_back(r);
  endfunction

  function automatic int pick_pad();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(4, 1);
    return $urandom_range(70, 10);  // long padding, which can run past the report buffer
  endfunction

  function automatic void random_bytes(input int n, output byte_q_t q);
    q.delete();
    repeat (n) q.push_back(8'($urandom));
  endfunction

  function automatic void build_report(input logic [7:0] hdr, input bit first,
                                       input byte_q_t body, input bit bad_check,
                                       input int pad, output byte_q_t rpt);
    logic [15:0] len;
    logic [7:0]  flags;
    logic [7:0]  chk;
    len   = 16'(body.size());
    flags = {first, 7'($urandom)};
    rpt   = {hdr, 8'($urandom), 8'($urandom), flags, len[7:0], len[15:8]};
    chk   = '0;
    foreach (rpt[i]) if (i > 0) chk ^= rpt[i];
    foreach (body[i]) begin
      rpt.push_back(body[i]);
      chk ^= body[i];
    end
    if (bad_check) chk ^= 8'($urandom_range(255, 1));
    rpt.push_back(chk);
    repeat (pad) rpt.push_back(8'($urandom));
  endfunction

  function automatic void build_message(input logic [7:0] cmd, input logic [7:0] code,
                                        input int plen, input bit bad_crc,
                                        output byte_q_t msg);
    logic [15:0] dl;
    logic [15:0] crc;
    dl  = 16'(plen);
    msg = {cmd, code, 8'($urandom), dl[7:0], dl[15:8]};
    repeat (plen) msg.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (msg[i]) crc = modbus_crc_step(crc, msg[i]);
    if (bad_crc) crc ^= 16'($urandom_range(16'hFFFF, 1));
    msg.push_back(crc[7:0]);
    msg.push_back(crc[15:8]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    while (!steady && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_deframe(b, last);
  endtask

  task automatic send_bytes(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // one acknowledgement message spread over as many reports as it takes
  task automatic send_ack(input logic [7:0] cmd, input logic [7:0] code, input int plen,
                          input bit bad_crc, input int extra);
    byte_q_t msg;
    byte_q_t body;
    byte_q_t rpt;
    int      n;
    bit      first;
    build_message(cmd, code, plen, bad_crc, msg);
    repeat (extra) msg.push_back(8'($urandom));
    first = 1'b1;
    while (msg.size() != 0) begin
      n = $urandom_range(MAX_CHUNK, first ? 7 : 1);
      body.delete();
      while (msg.size() != 0 && body.size() < n) body.push_back(msg.pop_front());
      build_report(reg_header, first, body, 1'b0, pick_pad(), rpt);
      send_bytes(rpt);
      first = 1'b0;
    end
  endtask

  // first report carrying only the message head, declaring dl payload bytes
  task automatic send_open_head(input logic [15:0] dl);
    byte_q_t head;
    byte_q_t rpt;
    head = {reg_command, 8'($urandom), 8'($urandom), dl[7:0], dl[15:8],
            8'($urandom), 8'($urandom)};
    build_report(reg_header, 1'b1, head, 1'b0, pick_pad(), rpt);
    send_bytes(rpt);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HEADER:      reg_header = value[7:0];
      CFG_ACK_COMMAND: reg_command = value[7:0];
      CFG_MAX_PAYLOAD: reg_max_payload = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] hdr, input logic [7:0] cmd,
                           input logic [12:0] max_len);
    wait_idle();
    cfg_put(CFG_HEADER, {5'b0, hdr});
    cfg_put(CFG_ACK_COMMAND, {5'b0, cmd});
    cfg_put(CFG_MAX_PAYLOAD, max_len);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_ack(8'h00, 8'h00, 0, 1'b0, 0);
    send_ack(8'h00, 8'hFF, 45, 1'b0, 0);
    send_open_head(16'd257);  // one past the reset limit
    send_open_head(16'd256);
    send_ack(8'h00, 8'h11, 3, 1'b0, 0);  // restarts the open message
  endtask

  task automatic test_report_errors();
    byte_q_t body;
    byte_q_t rpt;
    configure(8'hA5, 8'h3C, 13'd256);
    send_bytes({8'h5A});
    send_bytes({8'hA5, 8'h01, 8'h02, 8'h80});
    random_bytes(MAX_CHUNK + 1, body);
    build_report(reg_header, 1'b1, body, 1'b0, 0, rpt);
    send_bytes(rpt);
    build_message(reg_command, 8'h22, 0, 1'b0, body);
    build_report(reg_header, 1'b1, body, 1'b1, 0, rpt);
    send_bytes(rpt);
    random_bytes(5, body);
    build_report(reg_header, 1'b0, body, 1'b0, 0, rpt);
    send_bytes(rpt);
    random_bytes(4, body);
    build_report(reg_header, 1'b1, body, 1'b0, 0, rpt);
    send_bytes(rpt);
    // padding well past the report buffer
    build_message(reg_command, 8'h5A, 10, 1'b0, body);
    build_report(reg_header, 1'b1, body, 1'b0, 80, rpt);
    send_bytes(rpt);
  endtask

  task automatic test_message_errors();
    send_ack(reg_command ^ 8'h81, 8'h44, 5, 1'b0, 0);
    send_ack(reg_command, 8'h55, 20, 1'b1, 0);
    send_ack(reg_command, 8'h66, 2, 1'b0, 3);
    send_open_head(16'd100);
    send_ack(reg_command, 8'hFF, 120, 1'b0, 0);
    send_ack(reg_command, 8'h00, 1, 1'b0, 0);
  endtask

  task automatic test_limit_extremes();
    configure(8'hFF, 8'h00, 13'd0);
    send_ack(reg_command, 8'h77, 0, 1'b0, 0);
    send_open_head(16'd1);
    configure(8'h00, 8'hFF, 13'h1FFF);
    send_open_head(16'd4097);
    send_open_head(16'd4096);
    configure(8'h00, 8'hFF, LIMIT_CAP);
    send_open_head(16'd4097);
    send_open_head(16'd4096);
    send_ack(reg_command, 8'h88, 30, 1'b0, 0);
  endtask

  // receiver holds off while one-byte bad-header reports keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_requests <= hold_requests + 1;
    repeat (24) send_byte(~reg_header, 1'b1);
    send_ack(reg_command, 8'h99, 12, 1'b0, 0);
    send_ack(reg_command, 8'hAA, 0, 1'b0, 0);
  endtask

  task automatic random_report();
    byte_q_t    body;
    byte_q_t    rpt;
    int         limit;
    int         cap;
    int         plen;
    int         k;
    logic [7:0] cmd;
    limit = (reg_max_payload > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(reg_max_payload);
    cap   = ($urandom_range(9) == 0) ? 200 : 40;
    if (cap > limit) cap = limit;
    plen  = $urandom_range(cap, 0);
    if ($urandom_range(99) < 70) begin
      cmd = reg_command;
      if ($urandom_range(19) == 0) cmd = reg_command ^ 8'($urandom_range(255, 1));
      send_ack(cmd, 8'($urandom), plen, $urandom_range(19) == 0, 0);
    end else begin
      case ($urandom_range(6))
        0: begin
          random_bytes($urandom_range(20), body);
          build_report(reg_header ^ 8'($urandom_range(255, 1)), 1'b1, body, 1'b0,
                       pick_pad(), rpt);
          send_bytes(rpt);
        end
        1: begin
          random_bytes($urandom_range(30, 7), body);
          build_report(reg_header, 1'b1, body, 1'b0, 0, rpt);
          k = $urandom_range(rpt.size() - 1, 1);
          while (rpt.size() > k) rpt.delete(rpt.size() - 1);
          send_bytes(rpt);
        end
        2: begin
          random_bytes($urandom_range(20, 7), body);
          build_report(reg_header, 1'($urandom), body, 1'b1, pick_pad(), rpt);
          send_bytes(rpt);
        end
        3: begin
          random_bytes($urandom_range(20, 1), body);
          build_report(reg_header, 1'b0, body, 1'b0, pick_pad(), rpt);
          send_bytes(rpt);
        end
        4: begin
          random_bytes($urandom_range(6), body);
          build_report(reg_header, 1'b1, body, 1'b0, pick_pad(), rpt);
          send_bytes(rpt);
        end
        5: send_ack(reg_command, 8'($urandom), plen, 1'b0, $urandom_range(4, 1));
        default: begin
          random_bytes($urandom_range(70, 1), body);
          send_bytes(body);
        end
      endcase
    end
  endtask

  task automatic random_phase(input logic [7:0] hdr, input logic [7:0] cmd,
                              input logic [12:0] max_len, input bit quiet, input int count);
    int target;
    configure(hdr, cmd, max_len);
    steady <= quiet;
    target = items_sent + count;
    while (items_sent < target) random_report();
  endtask

  task automatic test_random();
    random_phase(8'hA5, 8'h3C, 13'd256, 1'b0, 100);
    random_phase(8'hFF, 8'h00, 13'd0, 1'b0, 100);
    random_phase(8'h00, 8'hFF, 13'h1FFF, 1'b1, 100);
    random_phase(8'($urandom), 8'($urandom), 13'($urandom_range(300)), 1'b0, 100);
    random_phase(8'h5A, 8'hC3, LIMIT_CAP, 1'b0, 100);
  endtask

  // result sink: random stalls, plus a long hold when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    amdc_result_t want;
    amdc_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = amdc_result_t'(out_tdata[24:0]);
      if (pending_acks.size() == 0) begin
        $error("unexpected result item: status %0d", got.status);
        errors++;
      end else begin
        want = pending_acks.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.ack_code != want.ack_code) begin
          $error("ack_code: expected %0h, got %0h", want.ack_code, got.ack_code);
          errors++;
        end
        if (got.message_length != want.message_length) begin
          $error("message_length: expected %0d, got %0d",
                 want.message_length, got.message_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reg_header      = '0;
    reg_command     = '0;
    reg_max_payload = MAX_PAYLOAD_RST;
    msg_open        = 1'b0;
    clear_report();
    clear_message();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_report_errors();
    test_message_errors();
    test_limit_extremes();
    test_backpressure();
    test_random();

    in_tvalid <= 1'b0;
    while (pending_acks.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_acks.size() != 0) begin
      $error("%0d expected results never arrived", pending_acks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
